### rtl/osp_pkg.sv
`default_nettype none

package osp_pkg;

  localparam int SEGMENTS_DEF = 64;
  localparam int X_W          = 16;
  localparam int Y_W          = 16;
  localparam int RELU_W       = 15;
  localparam int FRAC_W       = 11;
  localparam int MAG_W        = 17;
  localparam int KNOT_W       = 16;
  localparam int CORR_ACC_W   = 27;
  localparam int CORR_W       = 9;
  localparam int SUM_W        = 17;
  localparam int Y_ONE        = 256;
  localparam int Y_MAX        = 33024;
  localparam int RANGE_Q8     = 2048;
  localparam int ROUND_SHIFT  = 19;
  localparam longint Q30_ONE  = 64'sd1 << 30;

  typedef struct packed {
    logic signed [X_W-1:0] x_in;
    logic                  row_end;
  } osp_in_t;

  typedef struct packed {
    logic [Y_W-1:0] y_out;
    logic           row_end_out;
  } osp_out_t;

  typedef struct packed {
    logic              valid;
    logic              row_end;
    logic              in_range;
    logic [RELU_W-1:0] relu;
  } osp_ctl_t;

  // shift-subtract division, used only while building the knot table
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    int          b;
    q   = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint aa;
    longint bb;
    aa = (a < 0) ? 64'sd0 : a;
    bb = (b < 0) ? 64'sd0 : b;
    return (aa * bb) >>> 30;
  endfunction

  // e^-r for r in [0,1], q2.30
  function automatic longint exp_neg_frac(input longint r);
    longint sum;
    longint term;
    int     n;
    sum  = Q30_ONE;
    term = Q30_ONE;
    for (n = 1; n <= 20; n++) begin
      term = longint'(udiv(64'(q30_mul(term, r)), 64'(n)));
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > Q30_ONE) begin
      sum = Q30_ONE;
    end
    return sum;
  endfunction

  // ln(1+u) via 2*atanh(u/(2+u)), q2.30
  function automatic longint ln_one_plus(input longint u);
    longint uu;
    longint z;
    longint z2;
    longint p;
    longint acc;
    int     n;
    uu  = (u < 0) ? 64'sd0 : u;
    z   = longint'(udiv(64'(uu << 30), 64'(2 * Q30_ONE + uu)));
    z2  = q30_mul(z, z);
    p   = z;
    acc = 0;
    for (n = 0; n < 16; n++) begin
      acc = acc + longint'(udiv(64'(p), 64'(2 * n + 1)));
      p   = q30_mul(p, z2);
    end
    return 2 * acc;
  endfunction

  function automatic logic [KNOT_W-1:0] knot_value(input int k, input int segs);
    longint e1;
    longint t;
    longint m;
    longint u;
    longint c;
    longint j;
    e1 = exp_neg_frac(Q30_ONE);
    t  = longint'(udiv(64'(longint'(k)) << 33, 64'(segs)));
    m  = t >>> 30;
    u  = exp_neg_frac(t & (Q30_ONE - 1));
    for (j = 0; j < m; j++) begin
      u = q30_mul(u, e1);
    end
    c = ln_one_plus(u);
    return KNOT_W'((c + 64'sd8192) >>> 14);
  endfunction

endpackage

`default_nettype wire

### rtl/osp_index.sv
`default_nettype none

module osp_index
  import osp_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF,
  parameter int IDX_W    = $clog2(SEGMENTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire osp_in_t          operand,
  output logic      [IDX_W-1:0] idx,
  output logic     [FRAC_W-1:0] frac,
  output osp_ctl_t              ctl
);

  localparam int SEG_W = $clog2(SEGMENTS);
  localparam int P_W   = FRAC_W + SEG_W;

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [P_W-1:0]    prod;
  logic              valid;
  logic              row_end;
  logic              in_range;
  logic [RELU_W-1:0] relu;

  assign neg  = operand.x_in[X_W-1];
  assign mag  = neg ? (MAG_W'(1 << X_W) - MAG_W'(unsigned'(operand.x_in)))
                    : MAG_W'(unsigned'(operand.x_in));
  assign prod = P_W'(mag[FRAC_W-1:0]) * P_W'(SEGMENTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    row_end  <= operand.row_end;
    in_range <= (mag < MAG_W'(RANGE_Q8));
    relu     <= neg ? '0 : operand.x_in[RELU_W-1:0];
    idx      <= IDX_W'(prod[P_W-1:FRAC_W]);
    frac     <= prod[FRAC_W-1:0];
  end

  assign ctl = '{valid: valid, row_end: row_end, in_range: in_range, relu: relu};

endmodule

`default_nettype wire

### rtl/osp_knot_rom.sv
`default_nettype none

module osp_knot_rom
  import osp_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF,
  parameter int IDX_W    = $clog2(SEGMENTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic  [IDX_W-1:0] idx,
  input  wire logic [FRAC_W-1:0] frac_in,
  input  wire osp_ctl_t          ctl_in,
  output logic      [KNOT_W-1:0] lo,
  output logic      [KNOT_W-1:0] hi,
  output logic      [FRAC_W-1:0] frac,
  output osp_ctl_t               ctl
);

  logic [KNOT_W-1:0] knot_rom [SEGMENTS+1];
  logic [IDX_W-1:0]  idx_hi;
  logic              valid;
  osp_ctl_t          ctl_hold;

  for (genvar k = 0; k <= SEGMENTS; k++) begin : g_knot
    localparam logic [KNOT_W-1:0] KnotVal = knot_value(k, SEGMENTS);
    assign knot_rom[k] = KnotVal;
  end

  assign idx_hi = idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    lo       <= knot_rom[idx];
    hi       <= knot_rom[idx_hi];
    frac     <= frac_in;
    ctl_hold <= ctl_in;
  end

  assign ctl = '{valid: valid, row_end: ctl_hold.row_end, in_range: ctl_hold.in_range,
                 relu: ctl_hold.relu};

endmodule

`default_nettype wire

### rtl/osp_interp.sv
`default_nettype none

module osp_interp
  import osp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [KNOT_W-1:0] lo,
  input  wire logic [KNOT_W-1:0] hi,
  input  wire logic [FRAC_W-1:0] frac,
  input  wire osp_ctl_t          ctl_in,
  output osp_out_t               result,
  output logic                   result_valid
);

  localparam int DIFF_W = KNOT_W + 1;
  localparam int PROD_W = DIFF_W + FRAC_W + 1;
  localparam int ACC_W  = PROD_W + 1;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc;
  logic        [CORR_ACC_W-1:0] corr_acc;
  logic        [CORR_ACC_W-1:0] corr_acc_next;
  logic                         valid;
  osp_ctl_t                     ctl;
  logic        [CORR_ACC_W:0]   rounded;
  logic        [CORR_W-1:0]     corr;
  logic        [SUM_W-1:0]      sum;

  // correction in q0.27, clamped at zero
  assign diff          = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign prod          = diff * $signed({1'b0, frac});
  assign acc           = $signed(ACC_W'({lo, {FRAC_W{1'b0}}})) + ACC_W'(prod);
  assign corr_acc_next = acc[ACC_W-1] ? '0 : acc[CORR_ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    corr_acc <= corr_acc_next;
    ctl      <= ctl_in;
  end

  // round half up to q8.8 and add the linear part
  assign rounded = (CORR_ACC_W + 1)'(corr_acc) + (CORR_ACC_W + 1)'(1 << (ROUND_SHIFT - 1));
  assign corr    = ctl.in_range ? rounded[ROUND_SHIFT +: CORR_W] : '0;
  assign sum     = SUM_W'(Y_ONE) + SUM_W'(ctl.relu) + SUM_W'(corr);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    result.y_out       <= (sum > SUM_W'(Y_MAX)) ? Y_W'(Y_MAX) : sum[Y_W-1:0];
    result.row_end_out <= ctl.row_end;
  end

endmodule

`default_nettype wire

### rtl/oneplus_softplus_unit.sv
// channel   signals                  transaction when
// --------  -----------------------  ---------------------------------
// input     operand (x_in, row_end)  start && !busy at a rising edge
// result    result (y_out, row_end)  result_valid high for one cycle
//
// one element enters per cycle, and each result passes through the stages below in order
// stages: magnitude and index, knot rom read, interpolation multiply, round and sum
// busy is high only during reset; the knot table is a constant, no fill pass
// the result side has no stall, so the pipeline never holds
// row end travels alongside the data through every stage
`default_nettype none

module oneplus_softplus_unit
  import osp_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire osp_in_t  operand,
  output osp_out_t      result,
  output logic          result_valid
);

  localparam int IDX_W   = $clog2(SEGMENTS + 1);
  localparam int LATENCY = 4;

  logic              accept;
  logic [IDX_W-1:0]  idx;
  logic [FRAC_W-1:0] frac_s1;
  osp_ctl_t          ctl_s1;
  logic [KNOT_W-1:0] lo;
  logic [KNOT_W-1:0] hi;
  logic [FRAC_W-1:0] frac_s2;
  osp_ctl_t          ctl_s2;

  assign busy   = rst;
  assign accept = start && !busy;

  osp_index #(
    .SEGMENTS(SEGMENTS),
    .IDX_W   (IDX_W)
  ) u_index (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .operand(operand),
    .idx    (idx),
    .frac   (frac_s1),
    .ctl    (ctl_s1)
  );

  osp_knot_rom #(
    .SEGMENTS(SEGMENTS),
    .IDX_W   (IDX_W)
  ) u_knot_rom (
    .clk    (clk),
    .rst    (rst),
    .idx    (idx),
    .frac_in(frac_s1),
    .ctl_in (ctl_s1),
    .lo     (lo),
    .hi     (hi),
    .frac   (frac_s2),
    .ctl    (ctl_s2)
  );

  osp_interp u_interp (
    .clk         (clk),
    .rst         (rst),
    .lo          (lo),
    .hi          (hi),
    .frac        (frac_s2),
    .ctl_in      (ctl_s2),
    .result      (result),
    .result_valid(result_valid)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY result_valid)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, LATENCY))
    else $error("result without a matching transaction");

  a_row_end: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY (result.row_end_out == $past(operand.row_end, LATENCY)))
    else $error("row end flag lost in the pipeline");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.y_out >= Y_W'(Y_ONE)) && (result.y_out <= Y_W'(Y_MAX)))
    else $error("result outside output range");

  a_far_negative: assert property (@(posedge clk) disable iff (rst)
    (accept && (operand.x_in <= -X_W'(signed'(RANGE_Q8)))) |->
      ##LATENCY (result.y_out == Y_W'(Y_ONE)))
    else $error("far negative input must give one");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import osp_pkg::*;

  localparam int SEGMENTS     = SEGMENTS_DEF;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_MAX   = 10;
  localparam int PEND_DEPTH   = 16;
  localparam int PEND_W       = $clog2(PEND_DEPTH);

  logic     clk          = 1'b0;
  logic     rst          = 1'b1;
  logic     start        = 1'b0;
  osp_in_t  operand      = '0;
  logic     busy;
  osp_out_t result;
  logic     result_valid;

  logic [KNOT_W-1:0] corr_knot [0:SEGMENTS];
  osp_out_t          pending_y [PEND_DEPTH];
  logic [PEND_W-1:0] pend_wr      = '0;
  logic [PEND_W-1:0] pend_rd      = '0;
  int                pend_cnt     = 0;
  int                mismatch_cnt = 0;
  int                quiet_cycles = 0;
  bit                gaps_on      = 1'b0;
  int                burst_left   = 0;

  oneplus_softplus_unit #(
    .SEGMENTS(SEGMENTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand(operand),
    .result(result),
    .result_valid(result_valid)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fixed point q2.30 helpers for the correction table
  function automatic longint fx_prod(input longint a, input longint b);
    longint pa;
    longint pb;
    pa = (a < 0) ? 64'sd0 : a;
    pb = (b < 0) ? 64'sd0 : b;
    return (pa * pb) >>> 30;
  endfunction

  function automatic longint fx_exp_neg(input longint r);
    longint total;
    longint step;
    int     n;
    total = Q30_ONE;
    step  = Q30_ONE;
    for (n = 1; n <= 20; n++) begin
      step = fx_prod(step, r) / longint'(n);
      if (n % 2 == 1) begin
        total = total - step;
      end else begin
        total = total + step;
      end
    end
    if (total < 0) begin
      total = 0;
    end
    if (total > Q30_ONE) begin
      total = Q30_ONE;
    end
    return total;
  endfunction

  function automatic longint fx_log1p(input longint u);
    longint uc;
    longint z;
    longint zz;
    longint pw;
    longint sum;
    int     n;
    uc  = (u < 0) ? 64'sd0 : u;
    z   = (uc <<< 30) / (2 * Q30_ONE + uc);
    zz  = fx_prod(z, z);
    pw  = z;
    sum = 0;
    for (n = 0; n < 16; n++) begin
      sum = sum + pw / longint'(2 * n + 1);
      pw  = fx_prod(pw, zz);
    end
    return 2 * sum;
  endfunction

  function automatic void build_corr_knots();
    longint e_inv;
    longint t;
    longint whole;
    longint v;
    longint c;
    int     k;
    e_inv = fx_exp_neg(Q30_ONE);
    for (k = 0; k <= SEGMENTS; k++) begin
      t     = (longint'(k) <<< 33) / longint'(SEGMENTS);
      whole = t >>> 30;
      v     = fx_exp_neg(t & (Q30_ONE - 1));
      while (whole > 0) begin
        v     = fx_prod(v, e_inv);
        whole = whole - 1;
      end
      c            = fx_log1p(v);
      corr_knot[k] = KNOT_W'((c + 64'sd8192) >>> 14);
    end
  endfunction

  // 1 + max(x,0) + interpolated ln(1 + e^-|x|)
  function automatic osp_out_t oneplus_of(input osp_in_t item);
    osp_out_t    res;
    logic [15:0] raw;
    logic [16:0] mag;
    int unsigned relu;
    int unsigned corr;
    int unsigned y;
    int unsigned p;
    int unsigned seg;
    int unsigned frac;
    longint      lo;
    longint      hi;
    longint      acc;
    raw  = item.x_in;
    mag  = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    relu = raw[15] ? 0 : int'(raw);
    corr = 0;
    if (mag < RANGE_Q8) begin
      p    = int'(mag) * SEGMENTS;
      seg  = p >> FRAC_W;
      frac = p & 32'd2047;
      if (seg >= SEGMENTS) begin
        seg = SEGMENTS - 1;
      end
      lo  = longint'(corr_knot[seg]);
      hi  = longint'(corr_knot[seg + 1]);
      acc = lo * 2048 + (hi - lo) * longint'(frac);
      if (acc < 0) begin
        acc = 0;
      end
      corr = int'((acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
    end
    y = Y_ONE + relu + corr;
    if (y > Y_MAX) begin
      y = Y_MAX;
    end
    res.y_out       = y[15:0];
    res.row_end_out = item.row_end;
    return res;
  endfunction

  function automatic void log_mismatch(input string msg);
    if (mismatch_cnt < REPORT_MAX) begin
      $display("%0t: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endfunction

  // one transaction per edge on each side; the result side cannot stall
  always @(posedge clk) begin : result_check
    osp_out_t want;
    bit       moved;
    moved = 1'b0;
    if (start && !busy) begin
      if (pend_cnt >= PEND_DEPTH) begin
        log_mismatch("too many transactions in flight");
      end else begin
        pending_y[pend_wr] = oneplus_of(operand);
        pend_wr            = pend_wr + PEND_W'(1);
        pend_cnt++;
      end
      moved = 1'b1;
    end
    if (result_valid === 1'b1) begin
      moved = 1'b1;
      if (pend_cnt == 0) begin
        log_mismatch($sformatf("unexpected result y=%0d row_end=%0b",
                               result.y_out, result.row_end_out));
      end else begin
        want    = pending_y[pend_rd];
        pend_rd = pend_rd + PEND_W'(1);
        pend_cnt--;
        if (result.y_out !== want.y_out || result.row_end_out !== want.row_end_out) begin
          log_mismatch($sformatf("y exp %0d got %0d, row_end exp %0b got %0b",
                                 want.y_out, result.y_out,
                                 want.row_end_out, result.row_end_out));
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_elem(input logic signed [15:0] x, input logic re);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 60);
      end
      burst_left--;
    end
    start           <= 1'b1;
    operand.x_in    <= x;
    operand.row_end <= re;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  task automatic test_directed_edges();
    send_elem(16'sd0, 1'b0);
    send_elem(16'sd1, 1'b1);
    send_elem(-16'sd1, 1'b0);
    send_elem(16'sd32767, 1'b1);
    send_elem(-16'sd32768, 1'b0);
    send_elem(-16'sd32767, 1'b1);
    send_elem(16'sd2047, 1'b0);
    send_elem(-16'sd2047, 1'b0);
    send_elem(16'sd2048, 1'b1);
    send_elem(-16'sd2048, 1'b0);
    send_elem(16'sd2049, 1'b0);
    send_elem(-16'sd2049, 1'b1);
    send_elem(16'sh5555, 1'b0);
    send_elem(16'shAAAA, 1'b1);
  endtask

  // knot positions, half steps and the last segment
  task automatic test_knot_points();
    send_elem(16'sd32, 1'b0);
    send_elem(-16'sd32, 1'b0);
    send_elem(16'sd16, 1'b1);
    send_elem(-16'sd16, 1'b0);
    send_elem(16'sd2016, 1'b0);
    send_elem(-16'sd2016, 1'b1);
    send_elem(-16'sd2032, 1'b1);
  endtask

  task automatic test_random_rows(input int count);
    int                 sent;
    int                 row_len;
    int                 j;
    int                 sel;
    logic signed [15:0] x;
    logic               re;
    sent    = 0;
    gaps_on = 1'b1;
    while (sent < count) begin
      row_len = $urandom_range(1, 32);
      for (j = 0; j < row_len; j++) begin
        sel = $urandom_range(0, 9);
        if (sel <= 4) begin
          x = 16'($urandom_range(0, 2047));
        end else if (sel <= 7) begin
          x = 16'($urandom);
        end else if (sel == 8) begin
          x = 16'($urandom_range(2044, 2052));
        end else begin
          case ($urandom_range(0, 3))
            0: x = 16'sh7FFF;
            1: x = 16'sh8000;
            2: x = 16'sh8001;
            default: x = 16'sd0;
          endcase
        end
        if (sel != 9 && $urandom_range(0, 1)) begin
          x = -x;
        end
        re = (j == row_len - 1);
        if ($urandom_range(0, 19) == 0) begin
          re = 1'($urandom_range(0, 1));
        end
        send_elem(x, re);
        sent++;
      end
    end
    gaps_on = 1'b0;
  endtask

  initial begin
    build_corr_knots();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_knot_points();
    test_random_rows(1800);
    start <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/osp_pkg.sv
rtl/osp_index.sv
rtl/osp_knot_rom.sv
rtl/osp_interp.sv
rtl/oneplus_softplus_unit.sv
tb/tb_top.sv
